### sv/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

    localparam int MAX_FRAME_LENGTH = 64;
    localparam int MIN_FRAME_LENGTH = 5;
    localparam int LEN_W            = 7;
    localparam int LIMIT_W          = 3;
    localparam int IDX_W            = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;
    localparam int OUT_TDATA_W      = 32;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(3);

    localparam logic [LEN_W-1:0]   RST_FRAME_LENGTH = LEN_W'(5);
    localparam logic [LIMIT_W-1:0] RST_RETRY_LIMIT  = LIMIT_W'(3);
    localparam logic [7:0]         RST_STATION_ID   = 8'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH = 2'd0,
        CFG_RETRY_LIMIT  = 2'd1,
        CFG_STATION_ID   = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef enum logic [0:0] {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        VERDICT_GOOD          = 3'd0,
        VERDICT_BAD_FORMAT    = 3'd1,
        VERDICT_CHECK_RETRY   = 3'd2,
        VERDICT_CHECK_FAILED  = 3'd3,
        VERDICT_TIMEOUT_RETRY = 3'd4,
        VERDICT_TIMEOUT_FAIL  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [LEN_W-1:0]   frame_length;
        logic [LIMIT_W-1:0] retry_limit;
        logic [7:0]         station_id;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] payload_index;
        t_verdict         verdict;
        logic [7:0]       reply_byte;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

### sv/response_frame_checker.sv
`default_nettype none

// Response frame checker.
// Slave stream: one word per received byte. s_axis_tuser says whether the
// word is a received byte (0) or a receive timeout (1); s_axis_tdata is the
// byte. Master stream: at most one word per input word, either a payload
// byte (m_axis_tuser 0) or an attempt verdict with the ACK/NAK reply byte
// (m_axis_tuser 1); m_axis_tlast marks the end of a response.
// Header, ETX and the check of a frame produce no payload word.
// The result word passes the input register, then the result register, on
// its way to the master side. Throughput: one word per cycle while the
// master side does not stall, set by the position/XOR update in the
// checker core.
// A stalled master side holds the result register; the input register then
// holds its word only if it would produce a result, and s_axis_tready stays
// low while it does. Words without a result keep flowing.
// Configuration: i_cfg_valid/o_cfg_ready write port, always ready; index 0
// frame length, 1 retry limit, 2 station id. Write only while idle.
// Reset (i_rst_n low, synchronous) empties both registers, clears the frame
// position, check, fault flag and attempt count and restores default config.

module response_frame_checker
    import rfc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,  // rx_byte
    input  wire logic                   s_axis_tuser,  // operation

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // payload_byte[7:0], payload_index[13:8], verdict[16:14], reply_byte[24:17], zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser,  // kind
    output logic                        m_axis_tlast,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       w_cfg;
    logic       r_in_valid;
    t_op        r_in_op;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_has_result;
    t_result    w_result;
    logic       w_take;
    logic       w_in_acc;

    assign o_cfg_ready = 1'b1;

    rfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    rfc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_op         (r_in_op),
        .i_byte       (r_in_byte),
        .i_cfg        (w_cfg),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // Advance the held word when it makes no result or the result slot frees.
    assign w_take        = r_in_valid && (!w_has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_take;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.reply_byte, r_out.verdict,
                            r_out.payload_index, r_out.payload_byte};

endmodule

`default_nettype wire

### sv/rfc_cfg.sv
`default_nettype none

module rfc_cfg
    import rfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [LEN_W-1:0]   w_len;
    logic [LIMIT_W-1:0] w_limit;

    // Clamp on write so the core sees only legal values.
    always_comb begin
        w_len = i_data[LEN_W-1:0];
        if (w_len < LEN_W'(MIN_FRAME_LENGTH)) begin
            w_len = LEN_W'(MIN_FRAME_LENGTH);
        end else if (w_len > LEN_W'(MAX_FRAME_LENGTH)) begin
            w_len = LEN_W'(MAX_FRAME_LENGTH);
        end
        w_limit = i_data[LIMIT_W-1:0];
        if (w_limit == '0) begin
            w_limit = LIMIT_W'(1);
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_index'(i_index))
                CFG_FRAME_LENGTH: n_cfg.frame_length = w_len;
                CFG_RETRY_LIMIT:  n_cfg.retry_limit  = w_limit;
                CFG_STATION_ID:   n_cfg.station_id   = i_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length <= RST_FRAME_LENGTH;
            r_cfg.retry_limit  <= RST_RETRY_LIMIT;
            r_cfg.station_id   <= RST_STATION_ID;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/rfc_core.sv
`default_nettype none

module rfc_core
    import rfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire t_op        i_op,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_has_result,
    output t_result         o_result
);

    logic [LEN_W-1:0]   r_pos;
    logic [7:0]         r_check;
    logic               r_fault;
    logic [LIMIT_W-1:0] r_attempts;

    logic [LEN_W-1:0]   n_pos;
    logic [7:0]         n_check;
    logic               n_fault;
    logic [LIMIT_W-1:0] n_attempts;

    logic [LIMIT_W-1:0] w_attempt_inc;
    logic               w_give_up;
    logic               w_check_slot;
    logic [LEN_W-1:0]   w_payload_idx;

    assign w_attempt_inc = r_attempts + LIMIT_W'(1);
    assign w_give_up     = (w_attempt_inc >= i_cfg.retry_limit) || (w_attempt_inc == '0);
    assign w_check_slot  = (r_pos >= i_cfg.frame_length);
    assign w_payload_idx = r_pos - HEADER_BYTES;

    always_comb begin
        n_pos        = r_pos;
        n_check      = r_check;
        n_fault      = r_fault;
        n_attempts   = r_attempts;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_op == OP_TIMEOUT || w_check_slot) begin
            o_has_result        = 1'b1;
            o_result.kind       = KIND_VERDICT;
            n_pos               = '0;
            n_check             = '0;
            n_fault             = 1'b0;
            if (i_op == OP_BYTE && i_byte == r_check) begin
                o_result.verdict    = r_fault ? VERDICT_BAD_FORMAT : VERDICT_GOOD;
                o_result.reply_byte = ACK_BYTE;
                o_result.last       = 1'b1;
                n_attempts          = '0;
            end else begin
                o_result.reply_byte = NAK_BYTE;
                if (w_give_up) begin
                    o_result.verdict = (i_op == OP_TIMEOUT) ? VERDICT_TIMEOUT_FAIL
                                                            : VERDICT_CHECK_FAILED;
                    o_result.last    = 1'b1;
                    n_attempts       = '0;
                end else begin
                    o_result.verdict = (i_op == OP_TIMEOUT) ? VERDICT_TIMEOUT_RETRY
                                                            : VERDICT_CHECK_RETRY;
                    n_attempts       = w_attempt_inc;
                end
            end
        end else begin
            n_check = r_check ^ i_byte;
            n_pos   = r_pos + LEN_W'(1);
            if (r_pos == LEN_W'(0)) begin
                n_fault = r_fault | (i_byte != SOH_BYTE);
            end else if (r_pos == LEN_W'(1)) begin
                n_fault = r_fault | (i_byte != i_cfg.station_id);
            end else if (r_pos == LEN_W'(2)) begin
                n_fault = r_fault | (i_byte != STX_BYTE);
            end else if (r_pos == i_cfg.frame_length - LEN_W'(1)) begin
                n_fault = r_fault | (i_byte != ETX_BYTE);
            end else begin
                o_has_result           = 1'b1;
                o_result.kind          = KIND_PAYLOAD;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = w_payload_idx[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_check    <= '0;
            r_fault    <= 1'b0;
            r_attempts <= '0;
        end else if (i_take) begin
            r_pos      <= n_pos;
            r_check    <= n_check;
            r_fault    <= n_fault;
            r_attempts <= n_attempts;
        end
    end

`ifndef SYNTH
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LEN_W'(MAX_FRAME_LENGTH))
        else $error("frame position beyond maximum frame length");

    a_verdict_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_has_result && o_result.kind == KIND_VERDICT
        |=> r_pos == '0 && r_check == '0 && !r_fault)
        else $error("attempt state not cleared after verdict");

    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.kind == KIND_PAYLOAD
        |-> r_pos >= HEADER_BYTES && !w_check_slot)
        else $error("payload byte outside payload window");

    a_last_clears_attempts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_has_result && o_result.last |=> r_attempts == '0)
        else $error("attempt counter not cleared at end of response");
`endif

endmodule

`default_nettype wire

### dv/response_frame_checker_test.sv
`default_nettype none

module response_frame_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int N_PHASES      = 8;
    localparam int PHASE_WORDS   = 160;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } t_check;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        t_check     how;
        t_result    want;
    } t_stim_row;

    localparam t_result W_PAY_FF        = '{KIND_PAYLOAD, 8'hFF, 6'd0, VERDICT_GOOD, 8'h00, 1'b0};
    localparam t_result W_PAY_00        = '{KIND_PAYLOAD, 8'h00, 6'd0, VERDICT_GOOD, 8'h00, 1'b0};
    localparam t_result W_GOOD          = '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_GOOD, ACK_BYTE, 1'b1};
    localparam t_result W_BAD_FORMAT    =
        '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_BAD_FORMAT, ACK_BYTE, 1'b1};
    localparam t_result W_CHECK_RETRY   =
        '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_CHECK_RETRY, NAK_BYTE, 1'b0};
    localparam t_result W_CHECK_FAILED  =
        '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_CHECK_FAILED, NAK_BYTE, 1'b1};
    localparam t_result W_TIMEOUT_RETRY =
        '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_TIMEOUT_RETRY, NAK_BYTE, 1'b0};
    localparam t_result W_TIMEOUT_FAIL  =
        '{KIND_VERDICT, 8'h00, 6'd0, VERDICT_TIMEOUT_FAIL, NAK_BYTE, 1'b1};

    // default config: 5-byte frames, three attempts, station 0x50
    localparam t_stim_row SCRIPT [0:27] = '{
        '{OP_BYTE,    8'h01, CHK_NONE,  '0},
        '{OP_BYTE,    8'h50, CHK_NONE,  '0},
        '{OP_BYTE,    8'h02, CHK_NONE,  '0},
        '{OP_BYTE,    8'hFF, CHK_TYPED, W_PAY_FF},
        '{OP_BYTE,    8'h03, CHK_NONE,  '0},
        '{OP_BYTE,    8'hAF, CHK_TYPED, W_GOOD},
        '{OP_BYTE,    8'hFF, CHK_NONE,  '0},
        '{OP_BYTE,    8'h50, CHK_NONE,  '0},
        '{OP_BYTE,    8'h02, CHK_NONE,  '0},
        '{OP_BYTE,    8'h00, CHK_TYPED, W_PAY_00},
        '{OP_BYTE,    8'h03, CHK_NONE,  '0},
        '{OP_BYTE,    8'hAE, CHK_TYPED, W_BAD_FORMAT},
        '{OP_TIMEOUT, 8'hFF, CHK_TYPED, W_TIMEOUT_RETRY},
        '{OP_BYTE,    8'h01, CHK_MODEL, '0},
        '{OP_BYTE,    8'h50, CHK_MODEL, '0},
        '{OP_BYTE,    8'h02, CHK_MODEL, '0},
        '{OP_BYTE,    8'h80, CHK_MODEL, '0},
        '{OP_BYTE,    8'h03, CHK_MODEL, '0},
        '{OP_BYTE,    8'h00, CHK_TYPED, W_CHECK_RETRY},
        '{OP_BYTE,    8'h01, CHK_MODEL, '0},
        '{OP_BYTE,    8'h50, CHK_MODEL, '0},
        '{OP_BYTE,    8'h02, CHK_MODEL, '0},
        '{OP_BYTE,    8'h7F, CHK_MODEL, '0},
        '{OP_BYTE,    8'h03, CHK_MODEL, '0},
        '{OP_BYTE,    8'h00, CHK_TYPED, W_CHECK_FAILED},
        '{OP_TIMEOUT, 8'h00, CHK_TYPED, W_TIMEOUT_RETRY},
        '{OP_TIMEOUT, 8'h55, CHK_TYPED, W_TIMEOUT_RETRY},
        '{OP_TIMEOUT, 8'hAA, CHK_TYPED, W_TIMEOUT_FAIL}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [LEN_W-1:0]   cfg_len         = RST_FRAME_LENGTH;
    logic [LIMIT_W-1:0] cfg_limit       = RST_RETRY_LIMIT;
    logic [7:0]         cfg_station     = RST_STATION_ID;
    logic [LEN_W-1:0]   frame_pos       = '0;
    logic [7:0]         frame_xor       = '0;
    logic               frame_fault     = 1'b0;
    logic [LIMIT_W-1:0] failed_attempts = '0;

    t_result     outcome_q[$];
    int unsigned bytes_fed   = 0;
    int unsigned mismatches  = 0;
    int unsigned clean_pct   = 70;
    bit          idle_on     = 1'b1;
    bit          hold_rx     = 1'b0;

    response_frame_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL response_frame_checker");
        $finish;
    end

    function automatic int unsigned frame_bytes();
        if (cfg_len < MIN_FRAME_LENGTH) return MIN_FRAME_LENGTH;
        if (cfg_len > MAX_FRAME_LENGTH) return MAX_FRAME_LENGTH;
        return cfg_len;
    endfunction

    function automatic bit rx_word_outcome(input t_op op, input logic [7:0] b,
                                           output t_result r);
        int unsigned        len;
        logic [LEN_W-1:0]   pos;
        logic [LIMIT_W-1:0] lim;
        len = frame_bytes();
        pos = frame_pos;
        lim = (cfg_limit == '0) ? LIMIT_W'(1) : cfg_limit;
        r = '0;
        if (op == OP_TIMEOUT || pos >= len) begin
            r.kind = KIND_VERDICT;
            r.last = 1'b1;
            if (op == OP_BYTE && b == frame_xor) begin
                r.verdict    = frame_fault ? VERDICT_BAD_FORMAT : VERDICT_GOOD;
                r.reply_byte = ACK_BYTE;
                failed_attempts = '0;
            end else begin
                r.reply_byte = NAK_BYTE;
                failed_attempts = failed_attempts + 1'b1;
                if (failed_attempts >= lim || failed_attempts == '0) begin
                    failed_attempts = '0;
                    r.verdict = (op == OP_TIMEOUT) ? VERDICT_TIMEOUT_FAIL : VERDICT_CHECK_FAILED;
                end else begin
                    r.last    = 1'b0;
                    r.verdict = (op == OP_TIMEOUT) ? VERDICT_TIMEOUT_RETRY : VERDICT_CHECK_RETRY;
                end
            end
            frame_pos   = '0;
            frame_xor   = '0;
            frame_fault = 1'b0;
            return 1'b1;
        end
        frame_xor = frame_xor ^ b;
        frame_pos = pos + 1'b1;
        if ((pos == 0 && b != SOH_BYTE) || (pos == 1 && b != cfg_station) ||
            (pos == 2 && b != STX_BYTE) || (pos == len - 1 && b != ETX_BYTE))
            frame_fault = 1'b1;
        if (pos < HEADER_BYTES || pos == len - 1) return 1'b0;
        r.payload_byte  = b;
        r.payload_index = IDX_W'(pos - HEADER_BYTES);
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : reply_monitor
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected word: tuser %0b tdata 0x%0h tlast %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("payload_index", want.payload_index, m_axis_tdata[13:8]);
                check_field("verdict", want.verdict, m_axis_tdata[16:14]);
                check_field("reply_byte", want.reply_byte, m_axis_tdata[24:17]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    initial begin : reply_side
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_word(input t_op op, input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_fed++;
    endtask

    task automatic feed(input t_op op, input logic [7:0] b);
        t_result r;
        put_word(op, b);
        if (rx_word_outcome(op, b, r)) outcome_q.insert(outcome_q.size(), r);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_LENGTH: cfg_len     = d[LEN_W-1:0];
            CFG_RETRY_LIMIT:  cfg_limit   = d[LIMIT_W-1:0];
            CFG_STATION_ID:   cfg_station = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the input low until every expected word is back, then let the core settle
    task automatic drain();
        int n;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (outcome_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        if (outcome_q.size() != 0) begin
            $error("%0d expected words never arrived", outcome_q.size());
            mismatches++;
            outcome_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_frame();
        int unsigned len;
        int unsigned spot;
        int unsigned flavor;
        logic [7:0]  b;
        logic [7:0]  sum;
        len  = frame_bytes();
        spot = $urandom_range(0, len);
        flavor = ($urandom_range(0, 99) < clean_pct) ? 0 : $urandom_range(1, 10);
        sum  = 8'h00;
        if (flavor == 1) begin
            // loose words, then a timeout to realign
            repeat ($urandom_range(1, 4)) feed(t_op'($urandom_range(0, 1)), 8'($urandom));
            feed(OP_TIMEOUT, 8'($urandom));
            return;
        end
        if (flavor >= 7 && $urandom_range(0, 1) == 0) spot = len;
        for (int p = 0; p <= len; p++) begin
            if (flavor >= 2 && flavor <= 5 && p == spot) begin
                feed(OP_TIMEOUT, 8'($urandom));
                return;
            end
            if (p == 0)             b = SOH_BYTE;
            else if (p == 1)        b = cfg_station;
            else if (p == 2)        b = STX_BYTE;
            else if (p == len - 1)  b = ETX_BYTE;
            else if (p == len)      b = sum;
            else                    b = 8'($urandom);
            if (flavor >= 6 && p == spot) b = b ^ 8'($urandom_range(1, 255));
            feed(OP_BYTE, b);
            sum = sum ^ b;
        end
    endtask

    initial begin : stimulus
        t_result     r;
        int unsigned stop;
        logic [7:0]  len_d;
        logic [7:0]  lim_d;
        logic [7:0]  id_d;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(SCRIPT); i++) begin
            if (SCRIPT[i].how == CHK_MODEL) begin
                feed(SCRIPT[i].op, SCRIPT[i].data);
            end else begin
                put_word(SCRIPT[i].op, SCRIPT[i].data);
                void'(rx_word_outcome(SCRIPT[i].op, SCRIPT[i].data, r));
                if (SCRIPT[i].how == CHK_TYPED)
                    outcome_q.insert(outcome_q.size(), SCRIPT[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    len_d = 8'h00;
                    lim_d = 8'h07;
                    id_d  = 8'h00;
                    clean_pct = 10;
                end
                1: begin
                    len_d = 8'hFF;
                    lim_d = 8'hF8;
                    id_d  = 8'hFF;
                    clean_pct = 70;
                end
                default: begin
                    len_d = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                          : {1'($urandom), 7'($urandom_range(5, 12))};
                    lim_d = 8'($urandom);
                    id_d  = 8'($urandom);
                    clean_pct = $urandom_range(40, 90);
                end
            endcase
            write_reg(CFG_FRAME_LENGTH, len_d);
            write_reg(CFG_RETRY_LIMIT, lim_d);
            write_reg(CFG_STATION_ID, id_d);
            if (ph == 3) write_reg(CFG_UNUSED, 8'($urandom));
            if (ph == 2) hold_rx = 1'b1;
            if (ph == N_PHASES - 1) idle_on = 1'b0;
            stop = bytes_fed + PHASE_WORDS;
            while (bytes_fed < stop) random_frame();
        end

        drain();
        if (mismatches == 0)
            $display("PASS response_frame_checker");
        else
            $display("FAIL response_frame_checker");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/rfc_pkg.sv
sv/rfc_cfg.sv
sv/rfc_core.sv
sv/response_frame_checker.sv
dv/response_frame_checker_test.sv
